@@ src/sipist_pkg.sv @@
// Shared types, codes and helpers for the INVITE server transaction block.
package sipist_pkg;

    localparam int TIMER_WIDTH = 16;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    typedef logic [2:0] phase_t;
    typedef logic [2:0] mode_t;
    typedef logic [9:0] code_t;

    localparam phase_t PH_PROCEEDING = 3'd0;
    localparam phase_t PH_ACCEPTED   = 3'd1;
    localparam phase_t PH_COMPLETED  = 3'd2;
    localparam phase_t PH_CONFIRMED  = 3'd3;
    localparam phase_t PH_TERMINATED = 3'd4;

    localparam mode_t MODE_TICK     = 3'd0;
    localparam mode_t MODE_RESPONSE = 3'd1;
    localparam mode_t MODE_ACK      = 3'd2;
    localparam mode_t MODE_RETRANS  = 3'd3;
    localparam mode_t MODE_NEW_TXN  = 3'd4;

    localparam int TM_G = 0;
    localparam int TM_H = 1;
    localparam int TM_I = 2;
    localparam int TM_L = 3;

    localparam logic [3:0] REG_T1       = 4'h0;
    localparam logic [3:0] REG_T2       = 4'h4;
    localparam logic [3:0] REG_T4       = 4'h8;
    localparam logic [3:0] REG_RELIABLE = 4'hC;

    localparam logic [9:0]  T1_RESET = 10'd500;
    localparam logic [15:0] T2_RESET = 16'd4000;
    localparam logic [15:0] T4_RESET = 16'd5000;

    localparam code_t CODE_2XX_LOW = 10'd200;
    localparam code_t CODE_3XX_LOW = 10'd300;

    localparam logic [32:0] TMAX = 33'((64'd1 << TIMER_WIDTH) - 64'd1);

    // Clamps a value to the largest value a countdown can hold.
    function automatic timer_t sat_timer(input logic [32:0] v);
        logic [32:0] r;
        r = (v > TMAX) ? TMAX : v;
        return r[TIMER_WIDTH-1:0];
    endfunction

endpackage

@@ src/sip_invite_server_transaction_fsm.sv @@
// INVITE server transaction: event register, state update and result register.
//
//   Channel   Direction  Ports                          Content
//   s_        in         s_valid s_ready s_mode ...     one event request
//   m_        out        m_valid m_ready m_* flags      one result per event
//   APB       in/out     psel penable pwrite paddr ...  T1, T2, T4, reliable
//
// Each request is held in the event register and then moves to the result
// register, where its result is valid; one request can be taken every cycle
// while the result is not stalled. The state and timers update as a request
// moves from the event register to the result register. aresetn is synchronous
// and clears the state, the timers and both valid bits. A stalled result holds
// the event register, which in turn drops s_ready.
module sip_invite_server_transaction_fsm (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sipist_pkg::mode_t   s_mode,
    input  sipist_pkg::code_t   s_status_code,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_forward_response,
    output logic                m_retransmit_last,
    output logic                m_ack_to_user,
    output logic                m_rejected,
    output logic                m_terminated_now,
    output logic [2:0]          m_txn_state,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sipist_pkg::*;

    // Configuration registers
    logic [9:0]  t1_reg;
    logic [15:0] t2_reg;
    logic [15:0] t4_reg;
    logic        reliable_reg;

    // Event register
    logic   in_vld_reg;
    mode_t  mode_reg;
    code_t  code_reg;

    // Transaction state
    phase_t     phase_reg, phase_next;
    timer_t     interval_reg, interval_next;
    timer_t     cd_g_reg, cd_g_next;
    timer_t     cd_h_reg, cd_h_next;
    timer_t     cd_i_reg, cd_i_next;
    timer_t     cd_l_reg, cd_l_next;
    logic [3:0] active_reg, active_next;

    // Result register
    logic   out_vld_reg;
    logic   fwd_reg, fwd_next;
    logic   retx_reg, retx_next;
    logic   ackup_reg, ackup_next;
    logic   rej_reg, rej_next;
    logic   term_reg, term_next;
    phase_t state_reg;

    logic   advance;
    logic   cfg_write;

    timer_t t1_sat, t1x64_sat, t2_sat, t4_sat, doubled;
    logic   is_2xx, is_final_err;
    logic   fire_g, fire_h, fire_i, fire_l, tick_term;

    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        case (paddr)
            REG_T1:       prdata = {22'd0, t1_reg};
            REG_T2:       prdata = {16'd0, t2_reg};
            REG_T4:       prdata = {16'd0, t4_reg};
            REG_RELIABLE: prdata = {31'd0, reliable_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg       <= T1_RESET;
            t2_reg       <= T2_RESET;
            t4_reg       <= T4_RESET;
            reliable_reg <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_T1[3:2]:       t1_reg       <= pwdata[9:0];
                REG_T2[3:2]:       t2_reg       <= pwdata[15:0];
                REG_T4[3:2]:       t4_reg       <= pwdata[15:0];
                REG_RELIABLE[3:2]: reliable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign t1_sat    = sat_timer({23'd0, t1_reg});
    assign t1x64_sat = sat_timer({17'd0, t1_reg, 6'd0});
    assign t2_sat    = sat_timer({17'd0, t2_reg});
    assign t4_sat    = sat_timer({17'd0, t4_reg});

    // Next retransmit interval: doubled, clamped to the width and then to T2.
    always_comb begin
        timer_t dbl;
        dbl     = sat_timer(33'({interval_reg, 1'b0}));
        doubled = (dbl > t2_sat) ? t2_sat : dbl;
    end

    assign is_2xx       = (code_reg >= CODE_2XX_LOW) && (code_reg < CODE_3XX_LOW);
    assign is_final_err = (code_reg >= CODE_3XX_LOW);

    assign fire_g = active_reg[TM_G] && (cd_g_reg <= timer_t'(1));
    assign fire_h = active_reg[TM_H] && (cd_h_reg <= timer_t'(1));
    assign fire_i = active_reg[TM_I] && (cd_i_reg <= timer_t'(1));
    assign fire_l = active_reg[TM_L] && (cd_l_reg <= timer_t'(1));
    // Timer G never ends the transaction, so the phase seen by H, I and L is
    // the phase before the tick; any termination clears every timer anyway.
    assign tick_term = (fire_h && (phase_reg == PH_COMPLETED)) || fire_i || fire_l;

    always_comb begin
        phase_next    = phase_reg;
        interval_next = interval_reg;
        cd_g_next     = cd_g_reg;
        cd_h_next     = cd_h_reg;
        cd_i_next     = cd_i_reg;
        cd_l_next     = cd_l_reg;
        active_next   = active_reg;
        fwd_next      = 1'b0;
        retx_next     = 1'b0;
        ackup_next    = 1'b0;
        rej_next      = 1'b0;

        case (mode_reg)
            MODE_TICK: begin
                if (fire_g) begin
                    if (phase_reg == PH_COMPLETED) begin
                        retx_next     = 1'b1;
                        interval_next = doubled;
                        cd_g_next     = doubled;
                    end else begin
                        cd_g_next         = '0;
                        active_next[TM_G] = 1'b0;
                    end
                end else if (active_reg[TM_G]) begin
                    cd_g_next = cd_g_reg - timer_t'(1);
                end
                if (fire_h) begin
                    cd_h_next         = '0;
                    active_next[TM_H] = 1'b0;
                end else if (active_reg[TM_H]) begin
                    cd_h_next = cd_h_reg - timer_t'(1);
                end
                if (active_reg[TM_I]) begin
                    cd_i_next = fire_i ? '0 : cd_i_reg - timer_t'(1);
                end
                if (active_reg[TM_L]) begin
                    cd_l_next = fire_l ? '0 : cd_l_reg - timer_t'(1);
                end
                if (tick_term) begin
                    phase_next    = PH_TERMINATED;
                    interval_next = '0;
                    cd_g_next     = '0;
                    cd_h_next     = '0;
                    cd_i_next     = '0;
                    cd_l_next     = '0;
                    active_next   = '0;
                end
            end
            MODE_RESPONSE: begin
                if (phase_reg == PH_PROCEEDING) begin
                    fwd_next = 1'b1;
                    if (is_2xx) begin
                        phase_next        = PH_ACCEPTED;
                        cd_l_next         = t1x64_sat;
                        active_next[TM_L] = 1'b1;
                    end else if (is_final_err) begin
                        phase_next        = PH_COMPLETED;
                        if (!reliable_reg) begin
                            interval_next     = t1_sat;
                            cd_g_next         = t1_sat;
                            active_next[TM_G] = 1'b1;
                        end
                        cd_h_next         = t1x64_sat;
                        active_next[TM_H] = 1'b1;
                    end
                end else if (phase_reg == PH_ACCEPTED && is_2xx) begin
                    fwd_next = 1'b1;
                end else begin
                    rej_next = 1'b1;
                end
            end
            MODE_ACK: begin
                if (phase_reg == PH_COMPLETED) begin
                    cd_g_next         = '0;
                    interval_next     = '0;
                    active_next[TM_G] = 1'b0;
                    if (!reliable_reg) begin
                        phase_next        = PH_CONFIRMED;
                        cd_i_next         = t4_sat;
                        active_next[TM_I] = 1'b1;
                    end else begin
                        phase_next  = PH_TERMINATED;
                        cd_h_next   = '0;
                        cd_i_next   = '0;
                        cd_l_next   = '0;
                        active_next = '0;
                    end
                end else if (phase_reg == PH_ACCEPTED) begin
                    ackup_next = 1'b1;
                end else begin
                    rej_next = 1'b1;
                end
            end
            MODE_RETRANS: begin
                retx_next = (phase_reg == PH_PROCEEDING) || (phase_reg == PH_COMPLETED);
            end
            MODE_NEW_TXN: begin
                phase_next    = PH_PROCEEDING;
                interval_next = '0;
                cd_g_next     = '0;
                cd_h_next     = '0;
                cd_i_next     = '0;
                cd_l_next     = '0;
                active_next   = '0;
            end
            default: ;
        endcase

        term_next = (phase_next == PH_TERMINATED) && (phase_reg != PH_TERMINATED);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            phase_reg    <= PH_PROCEEDING;
            interval_reg <= '0;
            cd_g_reg     <= '0;
            cd_h_reg     <= '0;
            cd_i_reg     <= '0;
            cd_l_reg     <= '0;
            active_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg  <= 1'b1;
                phase_reg    <= phase_next;
                interval_reg <= interval_next;
                cd_g_reg     <= cd_g_next;
                cd_h_reg     <= cd_h_next;
                cd_i_reg     <= cd_i_next;
                cd_l_reg     <= cd_l_next;
                active_reg   <= active_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            code_reg <= s_status_code;
        end
        if (advance) begin
            fwd_reg   <= fwd_next;
            retx_reg  <= retx_next;
            ackup_reg <= ackup_next;
            rej_reg   <= rej_next;
            term_reg  <= term_next;
            state_reg <= phase_next;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_forward_response = fwd_reg;
    assign m_retransmit_last  = retx_reg;
    assign m_ack_to_user      = ackup_reg;
    assign m_rejected         = rej_reg;
    assign m_terminated_now   = term_reg;
    assign m_txn_state        = state_reg;

    // Timer G only runs while the final error response is retransmitted.
    a_g_in_completed: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg[TM_G] |-> (phase_reg == PH_COMPLETED))
        else $error("timer G active outside completed");

    a_i_in_confirmed: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg[TM_I] |-> (phase_reg == PH_CONFIRMED))
        else $error("timer I active outside confirmed");

    a_l_in_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg[TM_L] |-> (phase_reg == PH_ACCEPTED))
        else $error("timer L active outside accepted");

    a_term_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TERMINATED) |-> (active_reg == 4'd0))
        else $error("timers still active after termination");

    a_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_txn_state == phase_reg))
        else $error("reported state differs from transaction state");

endmodule
